// File: rtl/hkvt_pkg.sv
// ---------------------------------------------------------------------------
// hkvt_pkg
// Shared constants, codes and hash helpers of the hashed key-value table.
// ---------------------------------------------------------------------------
package hkvt_pkg;

  localparam int BUCKET_BITS_MAX_DEF = 10;
  localparam int WAYS_DEF            = 4;
  localparam int KEY_BYTES_DEF       = 8;

  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;
  localparam int CFG_W  = 4;
  localparam int HASH_W = 32;
  localparam int STAT_W = 2;

  localparam logic [CFG_W-1:0] TSIZE_RESET = 4'd10;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_DUPLICATE = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_BUCKET,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // One one-at-a-time round; the byte is sign-extended before the add.
  function automatic logic [HASH_W-1:0] hash_round(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
    logic [HASH_W-1:0] h1;
    logic [HASH_W-1:0] h2;
    h1 = h + {{(HASH_W-8){b[7]}}, b};
    h2 = h1 + (h1 << 10);
    return h2 ^ (h2 >> 6);
  endfunction

  function automatic logic [HASH_W-1:0] hash_final(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] f1;
    logic [HASH_W-1:0] f2;
    f1 = h + (h << 3);
    f2 = f1 ^ (f1 >> 11);
    return f2 + (f2 << 15);
  endfunction

endpackage

// File: rtl/hkvt_req_if.sv
// ---------------------------------------------------------------------------
// hkvt_req_if
// Request channel: opcode, key and value with valid/ready.
// ---------------------------------------------------------------------------
interface hkvt_req_if import hkvt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

// File: rtl/hkvt_rsp_if.sv
// ---------------------------------------------------------------------------
// hkvt_rsp_if
// Response channel: status and found value with valid/ready.
// ---------------------------------------------------------------------------
interface hkvt_rsp_if import hkvt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

// File: rtl/hkvt_cfg_if.sv
// ---------------------------------------------------------------------------
// hkvt_cfg_if
// Configuration write channel for table_size_log2.
// ---------------------------------------------------------------------------
interface hkvt_cfg_if import hkvt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/hkvt_hash_unit.sv
// ---------------------------------------------------------------------------
// hkvt_hash_unit
// Iterative one-at-a-time hash: one byte round per cycle, then a
// finalization step. The result holds until the next start.
// ---------------------------------------------------------------------------
module hkvt_hash_unit import hkvt_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [HASH_W-1:0] hash
);

  localparam int CW = $clog2(KEY_BYTES + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [KEY_W-1:0]  key_sr;
  logic [HASH_W-1:0] h;

  assign done = busy && (cnt == CW'(KEY_BYTES));
  assign hash = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h      <= '0;
      key_sr <= key;
    end else if (done) begin
      h <= hash_final(h);
    end else if (busy) begin
      h      <= hash_round(h, key_sr[7:0]);
      key_sr <= key_sr >> 8;
    end
  end

endmodule

// File: rtl/hashed_key_value_table_core.sv
// ---------------------------------------------------------------------------
// hashed_key_value_table_core
// Bucketed key-value table indexed by a one-at-a-time hash of the key.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   opcode, key, value
//   rsp      out  valid/ready   status, found_value
//   cfg      in   valid/ready   data (table_size_log2)
//
// After reset a clearing pass wipes all 2**BUCKET_BITS_MAX valid rows; req is
// held off until it ends, cfg is taken at all times.
// Each item passes through the hash, bucket, scan and decide states, and req
// is taken again only once it is decided: the hash unit runs one byte round
// per cycle, then the bucket's ways are read from the slot memory one per
// cycle. A pending response only stalls the block in its final decision state.
// ---------------------------------------------------------------------------
module hashed_key_value_table_core import hkvt_pkg::*; #(
  parameter int BUCKET_BITS_MAX = BUCKET_BITS_MAX_DEF,
  parameter int WAYS            = WAYS_DEF,
  parameter int KEY_BYTES       = KEY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hkvt_req_if.sink   req,
  hkvt_rsp_if.source rsp,
  hkvt_cfg_if.sink   cfg
);

  localparam int BB      = BUCKET_BITS_MAX;
  localparam int BUCKETS = 1 << BB;
  localparam int SLOTS   = BUCKETS * WAYS;
  localparam int SAW     = $clog2(SLOTS);
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [WW-1:0] LAST_WAY = WW'(WAYS - 1);
  localparam logic [BB-1:0] LAST_ROW = {BB{1'b1}};

  function automatic logic [BB-1:0] bucket_mask(input logic [CFG_W-1:0] bits);
    logic [BB-1:0] m;
    for (int i = 0; i < BB; i++) begin
      m[i] = (i < int'(bits));
    end
    return m;
  endfunction

  function automatic logic [SAW-1:0] slot_of(input logic [BB-1:0] b,
                                             input logic [WW-1:0] w);
    return SAW'(b) * SAW'(WAYS) + SAW'(w);
  endfunction

  // Control state
  state_t           state, state_next;
  logic [BB-1:0]    clr_cnt;
  logic [CFG_W-1:0] tsize;
  logic             rsp_valid;

  // Item datapath
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic [BB-1:0]    bucket_q;
  logic [WW-1:0]    way;
  logic             hit_q;
  logic [VAL_W-1:0] hit_val;
  logic             free_q;
  logic [WW-1:0]    free_way;
  logic [STAT_W-1:0] rsp_status;
  logic [VAL_W-1:0] rsp_value;

  // Hash unit
  logic              hash_start;
  logic              hash_done;
  logic [HASH_W-1:0] hash;
  logic [BB-1:0]     bucket_now;

  // Memories
  logic [WAYS-1:0]  vmem [BUCKETS];
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [WAYS-1:0]  vrow_q;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;

  logic             v_we;
  logic [BB-1:0]    v_waddr;
  logic [WAYS-1:0]  v_wdata;
  logic             v_re;
  logic             kv_we;
  logic [BB-1:0]    rd_bucket;
  logic [WW-1:0]    rd_way;

  logic             go;
  logic             ins_ok;

  hkvt_hash_unit #(.KEY_BYTES(KEY_BYTES)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (req.key),
    .done  (hash_done),
    .hash  (hash)
  );

  assign bucket_now = hash[BB-1:0] & bucket_mask(tsize);
  assign go         = !rsp_valid || rsp.ready;
  assign ins_ok     = op_q && !hit_q && free_q;

  assign cfg.ready       = 1'b1;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_value = rsp_value;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_cnt == LAST_ROW) state_next = ST_IDLE;
      ST_IDLE:   if (req.valid) state_next = ST_HASH;
      ST_HASH:   if (hash_done) state_next = ST_BUCKET;
      ST_BUCKET: state_next = ST_SCAN;
      ST_SCAN:   if (way == LAST_WAY) state_next = ST_DECIDE;
      ST_DECIDE: if (go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req.ready  = 1'b0;
    hash_start = 1'b0;
    v_we       = 1'b0;
    v_waddr    = bucket_q;
    v_wdata    = vrow_q | (WAYS'(1) << free_way);
    v_re       = 1'b0;
    kv_we      = 1'b0;
    rd_bucket  = bucket_q;
    rd_way     = way;
    unique case (state)
      ST_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_cnt;
        v_wdata = '0;
      end
      ST_IDLE: begin
        req.ready  = 1'b1;
        hash_start = req.valid;
      end
      ST_HASH: begin
      end
      ST_BUCKET: begin
        v_re      = 1'b1;
        rd_bucket = bucket_now;
        rd_way    = '0;
      end
      ST_SCAN: begin
        rd_way = (way == LAST_WAY) ? way : way + WW'(1);
      end
      ST_DECIDE: begin
        v_we  = go && ins_ok;
        kv_we = go && ins_ok;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      tsize     <= TSIZE_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + BB'(1);
      if (cfg.valid) tsize <= cfg.data;
      if (state == ST_DECIDE && go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      op_q    <= req.opcode;
      key_q   <= req.key;
      value_q <= req.value;
    end
    if (state == ST_BUCKET) begin
      bucket_q <= bucket_now;
      way      <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      free_way <= '0;
    end
    if (state == ST_SCAN) begin
      way <= way + WW'(1);
      if (vrow_q[way]) begin
        if (!hit_q && key_rd == key_q) begin
          hit_q   <= 1'b1;
          hit_val <= val_rd;
        end
      end else if (!free_q) begin
        free_q   <= 1'b1;
        free_way <= way;
      end
    end
    if (state == ST_DECIDE && go) begin
      rsp_value <= '0;
      if (op_q == OP_LOOKUP) begin
        if (hit_q) begin
          rsp_status <= STAT_OK;
          rsp_value  <= hit_val;
        end else begin
          rsp_status <= STAT_NOT_FOUND;
        end
      end else if (hit_q) begin
        rsp_status <= STAT_DUPLICATE;
      end else if (!free_q) begin
        rsp_status <= STAT_FULL;
      end else begin
        rsp_status <= STAT_OK;
      end
    end
  end

  // Valid rows: one row of way bits per bucket
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    if (v_re) vrow_q <= vmem[bucket_now];
  end

  // Key and value slots
  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[slot_of(bucket_q, free_way)] <= key_q;
      val_mem[slot_of(bucket_q, free_way)] <= value_q;
    end
    key_rd <= key_mem[slot_of(rd_bucket, rd_way)];
    val_rd <= val_mem[slot_of(rd_bucket, rd_way)];
  end

endmodule

// File: tb/tb_hashed_key_value_table_core.sv
// ---------------------------------------------------------------------------
// tb_hashed_key_value_table_core
// Self-checking bench for the hashed key-value table. A predictor holds its
// own copy of the slot store and the table size, hashes every accepted key
// and queues the expected response. The checker compares each response
// transfer with the oldest queued one. Directed cases run first, then random
// traffic over several table sizes, random gaps and stalls in all but one phase.
// ---------------------------------------------------------------------------
module tb_hashed_key_value_table_core;
  import hkvt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_TOTAL = (1 << BUCKET_BITS_MAX_DEF) * WAYS_DEF;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] found_value;
  } table_rsp_t;

  logic clk;
  logic rst;

  hkvt_req_if req_ch ();
  hkvt_rsp_if rsp_ch ();
  hkvt_cfg_if cfg_ch ();

  hashed_key_value_table_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // predictor state
  bit               slot_taken [SLOT_TOTAL];
  bit [KEY_W-1:0]   slot_key_copy [SLOT_TOTAL];
  bit [VAL_W-1:0]   slot_val_copy [SLOT_TOTAL];
  bit [CFG_W-1:0]   size_log2_copy;

  table_rsp_t       rsp_expected [$];
  bit [KEY_W-1:0]   stored_keys [$];
  int               mismatch_count;
  bit               src_gaps;
  bit               sink_stalls;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  function automatic bit [HASH_W-1:0] oaat_of_key(bit [KEY_W-1:0] k);
    bit [HASH_W-1:0] h;
    int i;
    h = '0;
    for (i = 0; i < KEY_BYTES_DEF; i++) begin
      // sign-extend each byte before the add
      h = h + {{(HASH_W-8){k[8*i+7]}}, k[8*i +: 8]};
      h = h + (h << 10);
      h = h ^ (h >> 6);
    end
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  function automatic table_rsp_t table_apply(opcode_t op, bit [KEY_W-1:0] k,
                                             bit [VAL_W-1:0] v);
    table_rsp_t r;
    bit [HASH_W-1:0] mask;
    int bits;
    int base;
    int hit;
    int free_way;
    int w;
    bits = (size_log2_copy > BUCKET_BITS_MAX_DEF) ? BUCKET_BITS_MAX_DEF : size_log2_copy;
    mask = (32'd1 << bits) - 32'd1;
    base = int'(oaat_of_key(k) & mask) * WAYS_DEF;
    hit = -1;
    free_way = -1;
    for (w = 0; w < WAYS_DEF; w++) begin
      if (slot_taken[base+w]) begin
        if (hit < 0 && slot_key_copy[base+w] == k) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    r.found_value = '0;
    if (op == OP_LOOKUP) begin
      if (hit >= 0) begin
        r.status = STAT_OK;
        r.found_value = slot_val_copy[base+hit];
      end else begin
        r.status = STAT_NOT_FOUND;
      end
    end else if (hit >= 0) begin
      r.status = STAT_DUPLICATE;
    end else if (free_way < 0) begin
      r.status = STAT_FULL;
    end else begin
      slot_taken[base+free_way] = 1'b1;
      slot_key_copy[base+free_way] = k;
      slot_val_copy[base+free_way] = v;
      stored_keys.push_back(k);
      r.status = STAT_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
  endtask

  // response side: random stalls when enabled
  always @(posedge clk) begin
    rsp_ch.ready <= sink_stalls ? ($urandom_range(99) >= 27) : 1'b1;
  end

  always @(posedge clk) begin
    table_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (rsp_expected.size() == 0) begin
        report_mismatch("unexpected response", 64'(rsp_ch.status), 64'd0);
      end else begin
        want = rsp_expected.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
        if (rsp_ch.found_value !== want.found_value)
          report_mismatch("found_value", rsp_ch.found_value, want.found_value);
      end
    end
  end

  // Leaves valid high after the transfer; the next call either drops it for a
  // gap or drives the next item in the same step.
  task automatic send_request(opcode_t op, bit [KEY_W-1:0] k, bit [VAL_W-1:0] v);
    if (src_gaps && $urandom_range(99) < 27) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key    <= k;
    req_ch.value  <= v;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    rsp_expected.push_back(table_apply(op, k, v));
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (rsp_expected.size() != 0);
  endtask

  task automatic set_table_size(bit [CFG_W-1:0] sz);
    wait_all_results();
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= sz;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    size_log2_copy = sz;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic bit [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mix plain random keys with keys in which most bytes are sign-edge values.
  function automatic bit [KEY_W-1:0] pick_key();
    bit [KEY_W-1:0] k;
    int i;
    k = rand_word();
    if ($urandom_range(3) == 0) begin
      for (i = 0; i < KEY_BYTES_DEF; i++) begin
        case ($urandom_range(4))
          0: k[8*i +: 8] = 8'h00;
          1: k[8*i +: 8] = 8'h7f;
          2: k[8*i +: 8] = 8'h80;
          3: k[8*i +: 8] = 8'hff;
          default: ;
        endcase
      end
    end
    return k;
  endfunction

  task automatic test_reset_size_basics();
    send_request(OP_LOOKUP, 64'h0, 64'h0);
    send_request(OP_INSERT, 64'h0, '1);
    send_request(OP_LOOKUP, 64'h0, 64'h1234_5678_9abc_def0);
    send_request(OP_INSERT, 64'h0, 64'h5555_5555_5555_5555);
    send_request(OP_INSERT, '1, 64'h0);
    send_request(OP_LOOKUP, '1, '1);
    send_request(OP_INSERT, 64'h8080_8080_8080_8080, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(OP_INSERT, 64'h7f7f_7f7f_7f7f_7f7f, 64'h5555_5555_5555_5555);
    send_request(OP_LOOKUP, 64'h8080_8080_8080_8080, 64'h0);
    send_request(OP_LOOKUP, 64'h7f7f_7f7f_7f7f_7f7f, 64'h0);
  endtask

  // One bucket only: the fifth distinct key finds it full.
  task automatic test_bucket_full();
    int i;
    set_table_size(4'd0);
    for (i = 1; i <= 5; i++)
      send_request(OP_INSERT, 64'h100 * i + 64'h1, rand_word());
    send_request(OP_INSERT, 64'h101, rand_word());
    send_request(OP_LOOKUP, 64'h501, 64'h0);
    send_request(OP_LOOKUP, 64'h301, 64'h0);
  endtask

  // Oversized setting saturates; shrinking strands earlier entries.
  task automatic test_size_change();
    set_table_size(4'd15);
    send_request(OP_INSERT, 64'hdead_beef_0bad_f00d, 64'h0123_4567_89ab_cdef);
    send_request(OP_LOOKUP, 64'hdead_beef_0bad_f00d, 64'h0);
    set_table_size(4'd3);
    send_request(OP_LOOKUP, 64'hdead_beef_0bad_f00d, 64'h0);
    send_request(OP_INSERT, 64'hdead_beef_0bad_f00d, 64'hfedc_ba98_7654_3210);
    send_request(OP_LOOKUP, 64'h0, 64'h0);
    send_request(OP_LOOKUP, 64'h8080_8080_8080_8080, 64'h0);
  endtask

  task automatic random_phase(bit [CFG_W-1:0] sz, int count);
    int n;
    int pick;
    bit [KEY_W-1:0] k;
    set_table_size(sz);
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      k = (stored_keys.size() != 0) ? stored_keys[$urandom_range(stored_keys.size()-1)]
                                    : pick_key();
      if (pick < 40)
        send_request(OP_INSERT, pick_key(), rand_word());
      else if (pick < 55)
        send_request(OP_INSERT, k, rand_word());
      else if (pick < 90)
        send_request(OP_LOOKUP, k, rand_word());
      else
        send_request(OP_LOOKUP, pick_key(), rand_word());
      // hold off now and then until the table has answered everything
      if (n % 97 == 96) wait_all_results();
    end
  endtask

  task automatic test_random_traffic();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    random_phase(4'd10, 300);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_phase(4'd10, 150);
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    random_phase(4'd4, 150);
    random_phase(4'd1, 80);
    random_phase(4'd12, 100);
    random_phase(4'd8, 70);
  endtask

  initial begin
    int i;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_LOOKUP;
    req_ch.key = '0;
    req_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    mismatch_count = 0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    size_log2_copy = TSIZE_RESET;
    for (i = 0; i < SLOT_TOTAL; i++) slot_taken[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_size_basics();
    test_bucket_full();
    test_size_change();
    test_random_traffic();

    wait_all_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: hashed_key_value_table_core.f
rtl/hkvt_pkg.sv
rtl/hkvt_req_if.sv
rtl/hkvt_rsp_if.sv
rtl/hkvt_cfg_if.sv
rtl/hkvt_hash_unit.sv
rtl/hashed_key_value_table_core.sv
tb/tb_hashed_key_value_table_core.sv
